@@ hw/rtl/bpus_pkg.sv @@
// Shared types, codes and timing constants for the board power-up sequencer.
`timescale 1ns / 1ps

package bpus_pkg;

	// Timebase: one input tick is one millisecond
	localparam int unsigned TICKS_PER_SECOND = 1000;

	// Wait counter width and fixed delays in ticks
	localparam int unsigned WAIT_W            = 18;
	localparam logic [WAIT_W-1:0] CONNECT_TICKS     = WAIT_W'(10);
	localparam logic [WAIT_W-1:0] PRESS_DELAY_TICKS = WAIT_W'(250);
	localparam logic [WAIT_W-1:0] PRESS_HOLD_TICKS  = WAIT_W'(100);

	// Request codes
	localparam logic [1:0] ACT_TICK      = 2'd0;
	localparam logic [1:0] ACT_POWER_ON  = 2'd1;
	localparam logic [1:0] ACT_POWER_OFF = 2'd2;
	localparam logic [1:0] ACT_SET_USB   = 2'd3;

	// Sequencer phase codes
	localparam int unsigned PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
	localparam logic [PHASE_W-1:0] PH_CONNECT = 3'd1;
	localparam logic [PHASE_W-1:0] PH_PRESS   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_REL_PWR = 3'd3;
	localparam logic [PHASE_W-1:0] PH_REL_FB  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_RUNNING = 3'd5;

	// Configuration register indexes
	localparam logic [1:0] REG_POWER_CONTROL = 2'd0;
	localparam logic [1:0] REG_POWER_KEY     = 2'd1;
	localparam logic [1:0] REG_FB_HOLD       = 2'd2;

	// Configuration seen by the sequencer core
	typedef struct packed {
		logic       has_power_control;
		logic       power_key_fitted;
		logic [7:0] fastboot_hold_seconds;
	} cfg_t;

	// Board levels after a step
	typedef struct packed {
		logic supply;
		logic usb;
		logic power_key;
		logic fastboot_key;
		logic running;
	} lvl_t;

endpackage

@@ hw/rtl/bpus_step.sv @@
// Sequencer core: phase, wait counter and board levels, updated once per request.
`timescale 1ns / 1ps

module bpus_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic [1:0]                    action,
	input  logic                          usb_request,
	input  bpus_pkg::cfg_t                cfg,
	output bpus_pkg::lvl_t                lvl
);

	logic [bpus_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [bpus_pkg::WAIT_W-1:0]  wait_q, wait_d;
	logic                         supply_q, supply_d;
	logic                         usb_q, usb_d;
	logic                         pkey_q, pkey_d;
	logic                         fbkey_q, fbkey_d;
	logic [bpus_pkg::WAIT_W-1:0]  hold_ticks;
	logic [bpus_pkg::PHASE_W-1:0] after_key_phase;
	logic [bpus_pkg::WAIT_W-1:0]  after_key_wait;
	logic                         expire;

	// Fastboot hold in ticks; 255 s of 1 ms ticks stays below the counter limit
	assign hold_ticks = bpus_pkg::WAIT_W'(cfg.fastboot_hold_seconds) *
		bpus_pkg::WAIT_W'(bpus_pkg::TICKS_PER_SECOND);

	// Pick the fastboot hold or go straight to running
	always_comb begin
		if (cfg.fastboot_hold_seconds != 8'd0) begin
			after_key_phase = bpus_pkg::PH_REL_FB;
			after_key_wait  = hold_ticks;
		end else begin
			after_key_phase = bpus_pkg::PH_RUNNING;
			after_key_wait  = '0;
		end
	end

	assign expire = (wait_q <= bpus_pkg::WAIT_W'(1));

	// Next state for one request
	always_comb begin
		phase_d = phase_q;
		wait_d  = wait_q;
		supply_d = supply_q;
		usb_d   = usb_q;
		pkey_d  = pkey_q;
		fbkey_d = fbkey_q;
		case (action)
			bpus_pkg::ACT_TICK: begin
				unique case (phase_q)
					bpus_pkg::PH_CONNECT: begin
						if (expire) begin
							supply_d = 1'b1;
							usb_d    = 1'b1;
							if (cfg.power_key_fitted) begin
								phase_d = bpus_pkg::PH_PRESS;
								wait_d  = bpus_pkg::PRESS_DELAY_TICKS;
							end else begin
								phase_d = after_key_phase;
								wait_d  = after_key_wait;
							end
						end else begin
							wait_d = wait_q - 1'b1;
						end
					end
					bpus_pkg::PH_PRESS: begin
						if (expire) begin
							pkey_d  = 1'b1;
							phase_d = bpus_pkg::PH_REL_PWR;
							wait_d  = bpus_pkg::PRESS_HOLD_TICKS;
						end else begin
							wait_d = wait_q - 1'b1;
						end
					end
					bpus_pkg::PH_REL_PWR: begin
						if (expire) begin
							pkey_d  = 1'b0;
							phase_d = after_key_phase;
							wait_d  = after_key_wait;
						end else begin
							wait_d = wait_q - 1'b1;
						end
					end
					bpus_pkg::PH_REL_FB: begin
						if (expire) begin
							fbkey_d = 1'b0;
							phase_d = bpus_pkg::PH_RUNNING;
							wait_d  = '0;
						end else begin
							wait_d = wait_q - 1'b1;
						end
					end
					bpus_pkg::PH_RUNNING: begin
						phase_d = phase_q;
					end
					default: begin
						// Idle, or an unreachable code: settle in idle
						phase_d = bpus_pkg::PH_IDLE;
						wait_d  = '0;
					end
				endcase
			end
			bpus_pkg::ACT_POWER_ON: begin
				if (cfg.has_power_control) begin
					if (cfg.fastboot_hold_seconds != 8'd0) begin
						fbkey_d = 1'b1;
					end
					if (cfg.power_key_fitted) begin
						pkey_d = 1'b0;
					end
					phase_d = bpus_pkg::PH_CONNECT;
					wait_d  = bpus_pkg::CONNECT_TICKS;
				end
			end
			bpus_pkg::ACT_POWER_OFF: begin
				// Drop supply and abort; keys and USB stay
				if (cfg.has_power_control) begin
					supply_d = 1'b0;
					phase_d  = bpus_pkg::PH_IDLE;
					wait_d   = '0;
				end
			end
			default: begin
				usb_d = usb_request;
			end
		endcase
	end

	// Hold state between requests, advance on each one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= bpus_pkg::PH_IDLE;
			wait_q   <= '0;
			supply_q <= 1'b0;
			usb_q    <= 1'b0;
			pkey_q   <= 1'b0;
			fbkey_q  <= 1'b0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			wait_q   <= wait_d;
			supply_q <= supply_d;
			usb_q    <= usb_d;
			pkey_q   <= pkey_d;
			fbkey_q  <= fbkey_d;
		end
	end

	assign lvl.supply       = supply_q;
	assign lvl.usb          = usb_q;
	assign lvl.power_key    = pkey_q;
	assign lvl.fastboot_key = fbkey_q;
	assign lvl.running      = (phase_q == bpus_pkg::PH_RUNNING);

endmodule

@@ hw/rtl/board_power_up_sequencer.sv @@
// Top level of the board power-up sequencer: register port, request pipeline, result.
//
// Channel   Direction  Handshake               Payload
// cfg       in         psel/penable/pready     paddr, pwdata, prdata
// in        in         in_valid/in_ready       action, usb_request
// out       out        out_valid/out_ready     supply_enabled .. board_running
//
// One request per cycle sustained while results are taken; a result passes the input
// register and then the sequencer state register that also serves as the result
// register. Reset clears the configuration, valid flags, phase and all levels.
// A stalled result holds the state; one more request waits in the input register.
`timescale 1ns / 1ps

module board_power_up_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic        usb_request,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        supply_enabled,
	output logic        usb_enabled,
	output logic        power_key_pressed,
	output logic        fastboot_key_pressed,
	output logic        board_running
);

	bpus_pkg::cfg_t cfg_q;
	bpus_pkg::lvl_t lvl;
	logic           valid_s1;
	logic [1:0]     action_s1;
	logic           usb_s1;
	logic           out_valid_q;
	logic           step_en;
	logic           cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				bpus_pkg::REG_POWER_CONTROL: cfg_q.has_power_control <= pwdata[0];
				bpus_pkg::REG_POWER_KEY:     cfg_q.power_key_fitted <= pwdata[0];
				bpus_pkg::REG_FB_HOLD:       cfg_q.fastboot_hold_seconds <= pwdata[7:0];
				default:                     cfg_q <= cfg_q;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (paddr[3:2])
			bpus_pkg::REG_POWER_CONTROL: prdata = {31'd0, cfg_q.has_power_control};
			bpus_pkg::REG_POWER_KEY:     prdata = {31'd0, cfg_q.power_key_fitted};
			bpus_pkg::REG_FB_HOLD:       prdata = {24'd0, cfg_q.fastboot_hold_seconds};
			default:                     prdata = '0;
		endcase
	end

	// Advance a request when the result slot is free or being taken
	assign step_en  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step_en;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			usb_s1    <= usb_request;
		end
	end

	// Mark the result valid until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	bpus_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (step_en),
		.action      (action_s1),
		.usb_request (usb_s1),
		.cfg         (cfg_q),
		.lvl         (lvl)
	);

	assign out_valid            = out_valid_q;
	assign supply_enabled       = lvl.supply;
	assign usb_enabled          = lvl.usb;
	assign power_key_pressed    = lvl.power_key;
	assign fastboot_key_pressed = lvl.fastboot_key;
	assign board_running        = lvl.running;

	// Running only comes after supply up; power-off leaves it when power control is set
	a_running_has_supply: assert property (@(posedge clk) disable iff (!arst_n)
		board_running |-> supply_enabled)
		else $error("running without supply");

	// A stepped request always produces a result
	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> out_valid)
		else $error("request stepped without result");

	// An accepted request is held in the input register next cycle
	a_accept_captured: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted request lost");

	// Levels only change when a request is stepped
	a_levels_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(lvl))
		else $error("levels changed without a request");

endmodule

@@ tb/bpus_checker.sv @@
// Level checker for the board power-up sequencer: predicts every result and compares it.
`timescale 1ns / 1ps

module bpus_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic        usb_request,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        supply_enabled,
	input  logic        usb_enabled,
	input  logic        power_key_pressed,
	input  logic        fastboot_key_pressed,
	input  logic        board_running,
	output int          mismatches,
	output int          levels_pending
);

	// Mirror of the configuration registers
	logic              cfg_power_control;
	logic              cfg_power_key;
	logic [7:0]        cfg_hold_seconds;

	// Mirror of the sequencer state
	logic [bpus_pkg::PHASE_W-1:0] seq_phase;
	logic [bpus_pkg::WAIT_W-1:0]  ticks_left;
	bpus_pkg::lvl_t               board;

	// Levels expected from requests already accepted, oldest first
	bpus_pkg::lvl_t levels_due[$];
	bpus_pkg::lvl_t want;

	// Start the fastboot hold, or go straight to running when no hold is set
	function automatic void hold_or_run();
		longint unsigned hold_len;
		hold_len = longint'(cfg_hold_seconds) * bpus_pkg::TICKS_PER_SECOND;
		if (cfg_hold_seconds != 8'd0) begin
			seq_phase = bpus_pkg::PH_REL_FB;
			ticks_left = (hold_len > {bpus_pkg::WAIT_W{1'b1}}) ?
				{bpus_pkg::WAIT_W{1'b1}} : hold_len[bpus_pkg::WAIT_W-1:0];
		end else begin
			seq_phase = bpus_pkg::PH_RUNNING;
			ticks_left = '0;
		end
	endfunction

	// Advance the board by one request and return the levels it leaves
	function automatic bpus_pkg::lvl_t next_board_levels(logic [1:0] act, logic usb_level_req);
		case (act)
			bpus_pkg::ACT_TICK: begin
				if (seq_phase >= bpus_pkg::PH_CONNECT && seq_phase <= bpus_pkg::PH_REL_FB) begin
					if (ticks_left <= 1) begin
						ticks_left = '0;
						case (seq_phase)
							bpus_pkg::PH_CONNECT: begin
								board.supply = 1'b1;
								board.usb = 1'b1;
								if (cfg_power_key) begin
									seq_phase = bpus_pkg::PH_PRESS;
									ticks_left = bpus_pkg::PRESS_DELAY_TICKS;
								end else begin
									hold_or_run();
								end
							end
							bpus_pkg::PH_PRESS: begin
								board.power_key = 1'b1;
								seq_phase = bpus_pkg::PH_REL_PWR;
								ticks_left = bpus_pkg::PRESS_HOLD_TICKS;
							end
							bpus_pkg::PH_REL_PWR: begin
								board.power_key = 1'b0;
								hold_or_run();
							end
							bpus_pkg::PH_REL_FB: begin
								board.fastboot_key = 1'b0;
								seq_phase = bpus_pkg::PH_RUNNING;
								ticks_left = '0;
							end
							default: ;
						endcase
					end else begin
						ticks_left = ticks_left - 1'b1;
					end
				end else if (seq_phase != bpus_pkg::PH_RUNNING) begin
					seq_phase = bpus_pkg::PH_IDLE;
					ticks_left = '0;
				end
			end
			bpus_pkg::ACT_POWER_ON: begin
				if (cfg_power_control) begin
					if (cfg_hold_seconds != 8'd0)
						board.fastboot_key = 1'b1;
					if (cfg_power_key)
						board.power_key = 1'b0;
					seq_phase = bpus_pkg::PH_CONNECT;
					ticks_left = bpus_pkg::CONNECT_TICKS;
				end
			end
			bpus_pkg::ACT_POWER_OFF: begin
				if (cfg_power_control) begin
					board.supply = 1'b0;
					seq_phase = bpus_pkg::PH_IDLE;
					ticks_left = '0;
				end
			end
			default: begin
				board.usb = usb_level_req;
			end
		endcase
		board.running = (seq_phase == bpus_pkg::PH_RUNNING);
		return board;
	endfunction

	// Compare one level of a result
	task automatic check_level(string field, logic expected_level, logic actual_level);
		if (actual_level !== expected_level) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0b, actual %0b",
				$time, field, expected_level, actual_level);
		end
	endtask

	// Track register writes, predict each request, and compare each result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_power_control = 1'b0;
			cfg_power_key = 1'b0;
			cfg_hold_seconds = 8'd0;
			seq_phase = bpus_pkg::PH_IDLE;
			ticks_left = '0;
			board = '0;
			levels_due.delete();
			mismatches = 0;
			levels_pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (levels_due.size() == 0) begin
					mismatches++;
					$display("%0t: result with no request pending, expected none, actual %b",
						$time, {supply_enabled, usb_enabled, power_key_pressed,
						fastboot_key_pressed, board_running});
				end else begin
					want = levels_due.pop_front();
					check_level("supply_enabled", want.supply, supply_enabled);
					check_level("usb_enabled", want.usb, usb_enabled);
					check_level("power_key_pressed", want.power_key, power_key_pressed);
					check_level("fastboot_key_pressed", want.fastboot_key, fastboot_key_pressed);
					check_level("board_running", want.running, board_running);
				end
			end
			if (in_valid && in_ready)
				levels_due.push_back(next_board_levels(action, usb_request));
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					bpus_pkg::REG_POWER_CONTROL: cfg_power_control = pwdata[0];
					bpus_pkg::REG_POWER_KEY:     cfg_power_key = pwdata[0];
					bpus_pkg::REG_FB_HOLD:       cfg_hold_seconds = pwdata[7:0];
					default: ;
				endcase
			end
			levels_pending = levels_due.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
// Top of the power-up sequencer testbench: clock, reset, register writes, requests, verdict.
`timescale 1ns / 1ps

module testbench;

	localparam int RESET_CYCLES    = 6;
	localparam int CYCLE_LIMIT     = 300000;
	localparam int LONG_STALL      = 80;
	localparam int STALL_AT_RESULT = 300;
	localparam int DRAIN_CYCLES    = 8;
	localparam int RANDOM_PHASES   = 3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = bpus_pkg::ACT_TICK;
	logic        usb_request = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        supply_enabled;
	logic        usb_enabled;
	logic        power_key_pressed;
	logic        fastboot_key_pressed;
	logic        board_running;

	int mismatches;
	int levels_pending;
	int cycle_count = 0;
	int results_taken = 0;
	bit no_gaps = 1'b0;

	board_power_up_sequencer dut (.*);

	bpus_checker level_check (.*);

	// Free-running clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Drive one register write; the caller drops psel after the last one
	task automatic write_reg(logic [1:0] index, logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {index, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	// Drop the request line, wait for the block to drain, then write all registers
	task automatic set_board_config(bit power_control, bit power_key, logic [7:0] hold_seconds);
		@(negedge clk);
		in_valid = 1'b0;
		while (levels_pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(bpus_pkg::REG_POWER_CONTROL, {31'd0, power_control});
		write_reg(bpus_pkg::REG_POWER_KEY, {31'd0, power_key});
		write_reg(bpus_pkg::REG_FB_HOLD, {24'd0, hold_seconds});
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// Offer one request after a random gap, none under no_gaps, and hold it until accepted
	task automatic send_request(logic [1:0] act, logic usb_level_req);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		usb_request = usb_level_req;
		do @(posedge clk); while (!in_ready);
	endtask

	// One configuration, optional power-on, ticks mixed with other requests, optional power-off
	task automatic run_phase(bit power_control, bit power_key, logic [7:0] hold_seconds,
			int tick_goal, bit noisy, bit start_on);
		int ticks;
		int pick;
		set_board_config(power_control, power_key, hold_seconds);
		no_gaps = ($urandom_range(0, 3) == 0);
		if (start_on)
			send_request(bpus_pkg::ACT_POWER_ON, 1'($urandom_range(0, 1)));
		ticks = 0;
		while (ticks < tick_goal) begin
			pick = $urandom_range(0, 99);
			if (pick < (noisy ? 80 : 95)) begin
				send_request(bpus_pkg::ACT_TICK, 1'($urandom_range(0, 1)));
				ticks++;
			end else if (!noisy || pick < 90) begin
				send_request(bpus_pkg::ACT_SET_USB, 1'($urandom_range(0, 1)));
			end else if (pick < 95) begin
				send_request(bpus_pkg::ACT_POWER_ON, 1'($urandom_range(0, 1)));
			end else begin
				send_request(bpus_pkg::ACT_POWER_OFF, 1'($urandom_range(0, 1)));
			end
		end
		if (noisy && $urandom_range(0, 1))
			send_request(bpus_pkg::ACT_POWER_OFF, 1'($urandom_range(0, 1)));
	endtask

	// Result side: random stall per result unless no_gaps, one long hold-off to fill the block
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (results_taken == STALL_AT_RESULT) begin
				out_ready = 1'b0;
				repeat (LONG_STALL) @(negedge clk);
			end
			stall = no_gaps ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			results_taken++;
		end
	end

	// Request side and verdict
	initial begin
		logic [7:0] hold_pick;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Reset configuration: power requests ignored, USB driven directly
		send_request(bpus_pkg::ACT_POWER_ON, 1'b0);
		send_request(bpus_pkg::ACT_POWER_OFF, 1'b1);
		send_request(bpus_pkg::ACT_SET_USB, 1'b1);
		send_request(bpus_pkg::ACT_SET_USB, 1'b0);
		send_request(bpus_pkg::ACT_TICK, 1'b1);

		// Short sequence to running, tick while running, restart, power off, idle tick
		set_board_config(1'b1, 1'b0, 8'd0);
		send_request(bpus_pkg::ACT_POWER_ON, 1'b1);
		repeat (10) send_request(bpus_pkg::ACT_TICK, 1'($urandom_range(0, 1)));
		send_request(bpus_pkg::ACT_TICK, 1'b0);
		send_request(bpus_pkg::ACT_POWER_ON, 1'b0);
		send_request(bpus_pkg::ACT_POWER_OFF, 1'b0);
		send_request(bpus_pkg::ACT_TICK, 1'b0);

		// Full sequence with power key and one-second fastboot hold, a few ticks running
		run_phase(1'b1, 1'b1, 8'd1, 1365, 1'b0, 1'b1);
		// Longest hold, left pending
		run_phase(1'b1, 1'b0, 8'd255, 20, 1'b0, 1'b1);
		// Supply control lost mid-sequence: power requests ignored, ticks go on
		run_phase(1'b0, 1'b1, 8'd2, 15, 1'b1, 1'b0);
		run_phase(1'b1, 1'b0, 8'd0, 20, 1'b1, 1'b1);

		// Random settings, some starting from the state the last phase left
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case ($urandom_range(0, 3))
				0: hold_pick = 8'd0;
				1: hold_pick = 8'd1;
				2: hold_pick = 8'd255;
				default: hold_pick = 8'($urandom_range(0, 255));
			endcase
			run_phase($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), hold_pick,
				$urandom_range(10, 30), 1'($urandom_range(0, 1)),
				$urandom_range(0, 4) != 0);
		end

		// Drain and give the verdict
		@(negedge clk);
		in_valid = 1'b0;
		while (levels_pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ board_power_up_sequencer.f @@
hw/rtl/bpus_pkg.sv
hw/rtl/bpus_step.sv
hw/rtl/board_power_up_sequencer.sv
tb/bpus_checker.sv
tb/testbench.sv
